// ===== rtl/core/tmhq_pkg.sv =====
// Shared types and constants for the timer min-heap sleep queue.
`default_nettype none
package tmhq_pkg;

  localparam int ID_W        = 5;
  localparam int NUM_IDS     = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int PORT_TIME_W = 48;
  localparam int COUNT_W     = 6;

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_DUP    = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RM_RD,
    ST_RM_DAT,
    ST_P_RD,
    ST_P_CMP,
    ST_SD_L,
    ST_SD_R,
    ST_SD_C,
    ST_CK_RD,
    ST_CK_CMP,
    ST_CK_DEC,
    ST_CK_POP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    status_t                status;
    logic                   valid;
    id_t                    id;
    logic [PORT_TIME_W-1:0] due;
    logic                   last;
  } result_t;

  localparam result_t RES_OK = '{status: STAT_OK, valid: 1'b0, id: '0, due: '0, last: 1'b1};

endpackage
`default_nettype wire

// ===== rtl/core/tmhq_ifs.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface tmhq_in_if;
  import tmhq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [ID_W-1:0]        thread_id;
  logic [PORT_TIME_W-1:0] timeout;
  logic [PORT_TIME_W-1:0] now_time;
  modport source (output valid, cmd, thread_id, timeout, now_time, input ready);
  modport sink (input valid, cmd, thread_id, timeout, now_time, output ready);
endinterface

interface tmhq_out_if;
  import tmhq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic                   expired_valid;
  logic [ID_W-1:0]        expired_id;
  logic [PORT_TIME_W-1:0] expired_due;
  logic [COUNT_W-1:0]     queue_count;
  logic                   last;
  modport source (output valid, status, expired_valid, expired_id, expired_due, queue_count,
                  last, input ready);
  modport sink (input valid, status, expired_valid, expired_id, expired_due, queue_count,
                last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tmhq_heap_mem.sv =====
// Heap storage: deadline and owner per slot, one write and one registered read port.
`default_nettype none
module tmhq_heap_mem #(
  parameter int DEPTH = 33,
  parameter int AW    = 6,
  parameter int DW    = 48
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [DW-1:0]             wdue,
  input  wire logic [tmhq_pkg::ID_W-1:0] wown,
  input  wire logic [AW-1:0]             raddr,
  output      logic [DW-1:0]             rd_due_r,
  output      logic [tmhq_pkg::ID_W-1:0] rd_own_r
);
  import tmhq_pkg::*;

  logic [DW-1:0]   due_mem [DEPTH];
  logic [ID_W-1:0] own_mem [DEPTH];

  // Write slot
  always_ff @(posedge clk) begin
    if (we) begin
      due_mem[waddr] <= wdue;
      own_mem[waddr] <= wown;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_due_r <= due_mem[raddr];
    rd_own_r <= own_mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/tmhq_slot_mem.sv =====
// Owner-to-slot map: heap slot of each queued id, registered read.
`default_nettype none
module tmhq_slot_mem #(
  parameter int SW = 6
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [tmhq_pkg::ID_W-1:0] waddr,
  input  wire logic [SW-1:0]             wdata,
  input  wire logic [tmhq_pkg::ID_W-1:0] raddr,
  output      logic [SW-1:0]             rdata_r
);
  import tmhq_pkg::*;

  logic [SW-1:0] slot_mem [NUM_IDS];

  // Write and read map
  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    rdata_r <= slot_mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/timer_min_heap_sleep_queue.sv =====
// Timer queue: min-heap of deadlines in one heap memory plus an owner-to-slot map.
// One transaction is worked at a time; the next is taken once the last result is loaded.
// Insert: the new entry walks the top-down path, one heap level per cycle.
// Remove: tail entry refills the freed slot; sift-down reads left child, then right child,
// then compares, per level on the single heap read port. Check clock: a removal per expiry.
// Reset clears control, count, last clock and queued bits; memories are not cleared.
`default_nettype none
module timer_min_heap_sleep_queue #(
  parameter int MAX_ENTRIES = 32,
  parameter int TIME_BITS   = 48
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tmhq_in_if.sink     in_ch,
  tmhq_out_if.source  out_ch
);
  import tmhq_pkg::*;

  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = $clog2(SW);
  localparam int TW = TIME_BITS;

  // Position of the highest set bit of a slot number
  function automatic logic [KW-1:0] msb_pos(input logic [SW-1:0] v);
    logic [KW-1:0] p;
    p = '0;
    for (int b = 0; b < SW; b++) begin
      if (v[b]) p = KW'(b);
    end
    return p;
  endfunction

  state_t              state_r, state_nxt;
  cmd_t                mode_r, mode_nxt;
  id_t                 op_id_r, op_id_nxt;
  logic [SW-1:0]       count_r, count_nxt;
  logic [TW-1:0]       last_clock_r, last_clock_nxt;
  logic [NUM_IDS-1:0]  queued_r, queued_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [SW-1:0]       i_r, i_nxt;
  logic [TW-1:0]       cur_due_r, cur_due_nxt;
  id_t                 cur_own_r, cur_own_nxt;
  logic [TW-1:0]       left_due_r, left_due_nxt;
  id_t                 left_own_r, left_own_nxt;
  logic                has_right_r, has_right_nxt;
  logic [TW-1:0]       root_due_r, root_due_nxt;
  id_t                 root_own_r, root_own_nxt;
  logic                more_r, more_nxt;
  logic                pend_r, pend_nxt;
  logic [TW-1:0]       pend_due_r, pend_due_nxt;
  id_t                 pend_own_r, pend_own_nxt;
  result_t             res_r, res_nxt;
  result_t             out_res_r, out_res_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                hp_we;
  logic [SW-1:0]       hp_waddr;
  logic [TW-1:0]       hp_wdue;
  id_t                 hp_wown;
  logic [SW-1:0]       hp_raddr;
  logic [TW-1:0]       hp_rd_due;
  id_t                 hp_rd_own;
  logic [SW-1:0]       sm_rd_slot;

  // Heap memory and owner map
  tmhq_heap_mem #(.DEPTH(MAX_ENTRIES + 1), .AW(SW), .DW(TW)) u_heap (
    .clk      (clk),
    .we       (hp_we),
    .waddr    (hp_waddr),
    .wdue     (hp_wdue),
    .wown     (hp_wown),
    .raddr    (hp_raddr),
    .rd_due_r (hp_rd_due),
    .rd_own_r (hp_rd_own)
  );

  tmhq_slot_mem #(.SW(SW)) u_slot (
    .clk     (clk),
    .we      (hp_we),
    .waddr   (hp_wown),
    .wdata   (hp_waddr),
    .raddr   (op_id_r),
    .rdata_r (sm_rd_slot)
  );

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      last_clock_r <= '0;
      queued_r     <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      last_clock_r <= last_clock_nxt;
      queued_r     <= queued_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    op_id_r     <= op_id_nxt;
    s_r         <= s_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    cur_due_r   <= cur_due_nxt;
    cur_own_r   <= cur_own_nxt;
    left_due_r  <= left_due_nxt;
    left_own_r  <= left_own_nxt;
    has_right_r <= has_right_nxt;
    root_due_r  <= root_due_nxt;
    root_own_r  <= root_own_nxt;
    more_r      <= more_nxt;
    pend_due_r  <= pend_due_nxt;
    pend_own_r  <= pend_own_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_count_r <= out_count_nxt;
  end

  // Next state, memory accesses and results
  always_comb begin
    logic [TW:0]     sum;
    logic [TW-1:0]   in_due;
    logic [SW-1:0]   cnt_inc;
    logic [SW-1:0]   path_a;
    logic [KW-1:0]   k_dec;
    logic [SW:0]     lchild;
    logic [SW:0]     rchild;
    logic            pick_r;
    logic [TW-1:0]   y_due;
    id_t             y_own;
    logic [SW-1:0]   y_addr;
    logic            finish;
    logic            load;

    state_nxt      = state_r;
    mode_nxt       = mode_r;
    op_id_nxt      = op_id_r;
    count_nxt      = count_r;
    last_clock_nxt = last_clock_r;
    queued_nxt     = queued_r;
    s_nxt          = s_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    cur_due_nxt    = cur_due_r;
    cur_own_nxt    = cur_own_r;
    left_due_nxt   = left_due_r;
    left_own_nxt   = left_own_r;
    has_right_nxt  = has_right_r;
    root_due_nxt   = root_due_r;
    root_own_nxt   = root_own_r;
    more_nxt       = more_r;
    pend_nxt       = pend_r;
    pend_due_nxt   = pend_due_r;
    pend_own_nxt   = pend_own_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    out_count_nxt  = out_count_r;
    hp_we          = 1'b0;
    hp_waddr       = i_r;
    hp_wdue        = cur_due_r;
    hp_wown        = cur_own_r;
    hp_raddr       = '0;
    in_ch.ready    = 1'b0;
    finish         = 1'b0;
    load           = 1'b0;

    sum     = {1'b0, last_clock_r} + {1'b0, TW'(in_ch.timeout)};
    in_due  = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    cnt_inc = count_r + 1'b1;
    path_a  = s_r >> k_r;
    k_dec   = k_r - 1'b1;
    lchild  = {i_r, 1'b0};
    rchild  = lchild + 1'b1;
    pick_r  = has_right_r && !(left_due_r < hp_rd_due);
    y_due   = pick_r ? hp_rd_due : left_due_r;
    y_own   = pick_r ? hp_rd_own : left_own_r;
    y_addr  = pick_r ? rchild[SW-1:0] : lchild[SW-1:0];

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt  = cmd_t'(in_ch.cmd);
          op_id_nxt = in_ch.thread_id;
          res_nxt   = RES_OK;
          case (cmd_t'(in_ch.cmd))
            CMD_INSERT: begin
              if (queued_r[in_ch.thread_id]) begin
                res_nxt.status = STAT_DUP;
                state_nxt      = ST_EMIT;
              end else if ({1'b0, count_r} >= (SW + 1)'(MAX_ENTRIES)) begin
                res_nxt.status = STAT_FULL;
                state_nxt      = ST_EMIT;
              end else begin
                count_nxt                   = cnt_inc;
                queued_nxt[in_ch.thread_id] = 1'b1;
                cur_due_nxt                 = in_due;
                cur_own_nxt                 = in_ch.thread_id;
                s_nxt                       = cnt_inc;
                k_nxt                       = msb_pos(cnt_inc);
                state_nxt                   = ST_P_RD;
              end
            end
            CMD_REMOVE: begin
              if (!queued_r[in_ch.thread_id] || count_r == '0) begin
                res_nxt.status = STAT_ABSENT;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_RM_RD;
              end
            end
            CMD_CHECK: begin
              last_clock_nxt = TW'(in_ch.now_time);
              pend_nxt       = 1'b0;
              state_nxt      = ST_CK_RD;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Fetch tail entry and the slot of the id to drop
      ST_RM_RD: begin
        hp_raddr  = count_r;
        state_nxt = ST_RM_DAT;
      end

      ST_RM_DAT: begin
        count_nxt          = count_r - 1'b1;
        queued_nxt[op_id_r] = 1'b0;
        if (hp_rd_own == op_id_r) begin
          finish = 1'b1;
        end else begin
          cur_due_nxt = hp_rd_due;
          cur_own_nxt = hp_rd_own;
          s_nxt       = sm_rd_slot;
          k_nxt       = msb_pos(sm_rd_slot);
          state_nxt   = ST_P_RD;
        end
      end

      // Start the top-down walk toward slot s
      ST_P_RD: begin
        if (k_r == '0) begin
          i_nxt     = s_r;
          state_nxt = ST_SD_L;
        end else begin
          hp_raddr  = path_a;
          state_nxt = ST_P_CMP;
        end
      end

      // Take the slot if strictly smaller, carry the old entry down
      ST_P_CMP: begin
        if (cur_due_r < hp_rd_due) begin
          hp_we       = 1'b1;
          hp_waddr    = path_a;
          cur_due_nxt = hp_rd_due;
          cur_own_nxt = hp_rd_own;
        end
        k_nxt = k_dec;
        if (k_dec == '0) begin
          i_nxt     = s_r;
          state_nxt = ST_SD_L;
        end else begin
          hp_raddr = s_r >> k_dec;
        end
      end

      // Sift down: stop at a leaf, else fetch left child
      ST_SD_L: begin
        if (lchild > {1'b0, count_r}) begin
          hp_we  = 1'b1;
          finish = 1'b1;
        end else begin
          hp_raddr  = lchild[SW-1:0];
          state_nxt = ST_SD_R;
        end
      end

      ST_SD_R: begin
        left_due_nxt  = hp_rd_due;
        left_own_nxt  = hp_rd_own;
        has_right_nxt = rchild <= {1'b0, count_r};
        hp_raddr      = rchild[SW-1:0];
        state_nxt     = ST_SD_C;
      end

      ST_SD_C: begin
        hp_we = 1'b1;
        if (cur_due_r > y_due) begin
          hp_wdue   = y_due;
          hp_wown   = y_own;
          i_nxt     = y_addr;
          state_nxt = ST_SD_L;
        end else begin
          finish = 1'b1;
        end
      end

      // Check clock: look at the root
      ST_CK_RD: begin
        if (count_r == '0) begin
          more_nxt  = 1'b0;
          state_nxt = ST_CK_DEC;
        end else begin
          hp_raddr  = SW'(1);
          state_nxt = ST_CK_CMP;
        end
      end

      ST_CK_CMP: begin
        root_due_nxt = hp_rd_due;
        root_own_nxt = hp_rd_own;
        more_nxt     = hp_rd_due <= last_clock_r;
        state_nxt    = ST_CK_DEC;
      end

      // Release the held expiry once the next root is known
      ST_CK_DEC: begin
        if (pend_r) begin
          res_nxt       = RES_OK;
          res_nxt.valid = 1'b1;
          res_nxt.id    = pend_own_r;
          res_nxt.due   = PORT_TIME_W'(pend_due_r);
          res_nxt.last  = !more_r;
          pend_nxt      = 1'b0;
          state_nxt     = ST_EMIT;
        end else if (more_r) begin
          state_nxt = ST_CK_POP;
        end else begin
          res_nxt   = RES_OK;
          state_nxt = ST_EMIT;
        end
      end

      ST_CK_POP: begin
        pend_nxt     = 1'b1;
        pend_due_nxt = root_due_r;
        pend_own_nxt = root_own_r;
        op_id_nxt    = root_own_r;
        state_nxt    = ST_RM_RD;
      end

      // Hand the result to the output register
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = res_r.last ? ST_IDLE : ST_CK_POP;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (mode_r == CMD_CHECK) begin
        state_nxt = ST_CK_RD;
      end else begin
        res_nxt   = RES_OK;
        state_nxt = ST_EMIT;
      end
    end

    if (load) begin
      out_res_nxt   = res_r;
      out_count_nxt = COUNT_W'(count_r);
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  // Output register
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.expired_valid = out_res_r.valid;
  assign out_ch.expired_id    = out_res_r.id;
  assign out_ch.expired_due   = out_res_r.due;
  assign out_ch.queue_count   = out_count_r;
  assign out_ch.last          = out_res_r.last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= (SW + 1)'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_queued_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(count_r))
    else $error("queued ids disagree with entry count");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r != ST_IDLE)
    else $error("accepted transaction not started");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.valid) |-> (out_res_r.status == STAT_OK))
    else $error("expiry result with error status");

endmodule
`default_nettype wire
